// ===== hdl/chs_pkg.sv =====
// shared types and constants for the chained hash set lookup
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

   localparam int KEY_W = 31;

   typedef struct packed {
      logic             req_type;
      logic [KEY_W-1:0] key;
   } chs_req_type;

   typedef struct packed {
      logic found;
      logic overflow;
   } chs_rsp_type;

endpackage

`default_nettype wire

// ===== hdl/chs_rem.sv =====
// remainder unit: key modulo the bucket count by mask or reciprocal multiply
`timescale 1ns / 1ps
`default_nettype none

module chs_rem #(
   parameter int NUM_BUCKETS = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [chs_pkg::KEY_W-1:0]       dividend,
   output logic                                 done,
   output logic [$clog2(NUM_BUCKETS)-1:0]       rem
);
   import chs_pkg::*;

   localparam int BW = $clog2(NUM_BUCKETS);
   localparam bit POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

   logic          done_ff, done_in;
   logic [BW-1:0] rem_ff, rem_in;

   generate
      if (POW2) begin : g_mask
         always_comb begin
            done_in = start;
            rem_in  = start ? dividend[BW-1:0] : rem_ff;
         end
      end else begin : g_recip
         // exact quotient from key * ceil(2^(KEY_W+BW) / NUM_BUCKETS) >> (KEY_W+BW)
         localparam int SH = KEY_W + BW;
         localparam int PW = KEY_W + 32;
         localparam longint unsigned RECIP_L =
            ((64'd1 << SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
         localparam logic [31:0] RECIP = 32'(RECIP_L);

         logic             run_ff, run_in;
         logic [KEY_W-1:0] num_ff, num_in;
         logic [PW-1:0]    prod_ff, prod_in;
         logic [BW-1:0]    quot_lo;
         logic [BW-1:0]    back;

         always_comb begin
            quot_lo = BW'(prod_ff >> SH);
            back    = quot_lo * BW'(NUM_BUCKETS);
            run_in  = start;
            num_in  = start ? dividend : num_ff;
            prod_in = start ? PW'(dividend) * PW'(RECIP) : prod_ff;
            done_in = run_ff;
            // remainder is below the bucket count, so the low bits suffice
            rem_in  = run_ff ? num_ff[BW-1:0] - back : rem_ff;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               run_ff <= 1'b0;
            end else begin
               run_ff <= run_in;
            end
            num_ff  <= num_in;
            prod_ff <= prod_in;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

// ===== hdl/chained_hash_set_lookup_top.sv =====
// top level of the chained hash set: bucket memories and request sequencer
// latency: an insert raises its result strobe after the remainder, fill read and check states,
//   with busy dropping at the same edge; a search adds a read and compare per slot examined
// a bucket count that is not a power of two adds the multiply register in the remainder unit
// throughput: one request at a time; a new request is taken only in the idle state
// reset: busy stays high for a clearing pass that zeroes the fill count of every bucket
// results are strobed for one cycle; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none

module chained_hash_set_lookup_top #(
   parameter int NUM_BUCKETS = 4096,
   parameter int BUCKET_WAYS = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire chs_pkg::chs_req_type req_item,
   output logic                      rsp_valid,
   output chs_pkg::chs_rsp_type      rsp_item
);
   import chs_pkg::*;

   localparam int BW    = $clog2(NUM_BUCKETS);
   localparam int FW    = $clog2(BUCKET_WAYS + 1);
   localparam int SLOTS = NUM_BUCKETS * BUCKET_WAYS;
   localparam int SA_W  = $clog2(SLOTS);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_FRD  = 3'd3;
   localparam logic [2:0] S_FCHK = 3'd4;
   localparam logic [2:0] S_SRD  = 3'd5;
   localparam logic [2:0] S_SCMP = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [BW-1:0]    clr_ff, clr_in;
   logic             search_ff, search_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [BW-1:0]    bucket_ff, bucket_in;
   logic [SA_W-1:0]  base_ff, base_in;
   logic [FW-1:0]    idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   chs_rsp_type      rsp_ff, rsp_in;

   logic [FW-1:0]    fill_mem [NUM_BUCKETS];
   logic [KEY_W-1:0] slot_mem [SLOTS];
   logic [FW-1:0]    fill_rd_ff;
   logic [KEY_W-1:0] slot_rd_ff;

   logic             fill_we;
   logic [BW-1:0]    fill_waddr;
   logic [FW-1:0]    fill_wdata;
   logic             slot_we;
   logic [SA_W-1:0]  slot_waddr;
   logic [SA_W-1:0]  slot_raddr;

   logic             rem_start;
   logic             rem_done;
   logic [BW-1:0]    rem_bucket;
   logic [FW-1:0]    idx_next;

   chs_rem #(
      .NUM_BUCKETS(NUM_BUCKETS)
   ) u_rem (
      .clock   (clock),
      .reset   (reset),
      .start   (rem_start),
      .dividend(req_item.key),
      .done    (rem_done),
      .rem     (rem_bucket)
   );

   assign slot_raddr = base_ff + SA_W'(idx_ff);
   assign idx_next   = idx_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      search_in    = search_ff;
      key_in       = key_ff;
      bucket_in    = bucket_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rem_start    = 1'b0;
      fill_we      = 1'b0;
      fill_waddr   = bucket_ff;
      fill_wdata   = fill_rd_ff + 1'b1;
      slot_we      = 1'b0;
      slot_waddr   = base_ff + SA_W'(fill_rd_ff);
      unique case (state_ff)
         S_CLR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_ff;
            fill_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == BW'(NUM_BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               search_in = req_item.req_type;
               key_in    = req_item.key;
               rem_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_done) begin
               bucket_in = rem_bucket;
               state_in  = S_FRD;
            end
         end
         S_FRD: begin
            base_in  = SA_W'(bucket_ff) * SA_W'(BUCKET_WAYS);
            state_in = S_FCHK;
         end
         S_FCHK: begin
            idx_in = '0;
            if (!search_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in.found = 1'b0;
               state_in     = S_IDLE;
               if (fill_rd_ff >= FW'(BUCKET_WAYS)) begin
                  rsp_in.overflow = 1'b1;
               end else begin
                  rsp_in.overflow = 1'b0;
                  fill_we         = 1'b1;
                  slot_we         = 1'b1;
               end
            end else if (fill_rd_ff == '0) begin
               rsp_valid_in    = 1'b1;
               rsp_in.found    = 1'b0;
               rsp_in.overflow = 1'b0;
               state_in        = S_IDLE;
            end else begin
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            state_in = S_SCMP;
         end
         S_SCMP: begin
            idx_in = idx_next;
            if (slot_rd_ff == key_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_in.found    = 1'b1;
               rsp_in.overflow = 1'b0;
               state_in        = S_IDLE;
            end else if (idx_next == fill_rd_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_in.found    = 1'b0;
               rsp_in.overflow = 1'b0;
               state_in        = S_IDLE;
            end else begin
               state_in = S_SRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      search_ff <= search_in;
      key_ff    <= key_in;
      bucket_ff <= bucket_in;
      base_ff   <= base_in;
      idx_ff    <= idx_in;
      rsp_ff    <= rsp_in;
   end

   // bucket fill counts
   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_waddr] <= fill_wdata;
      end
      fill_rd_ff <= fill_mem[bucket_ff];
   end

   // slot keys
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= key_ff;
      end
      slot_rd_ff <= slot_mem[slot_raddr];
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.found && rsp_ff.overflow))
      else $error("found and overflow raised together");

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but busy not raised");

   a_quiet_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> !rsp_valid_ff)
      else $error("result strobed during the clearing pass");

endmodule

`default_nettype wire
